// ===== src/random_walk_quote_generator_defines.svh =====
// Assertion macros for the random-walk quote generator.
// Included by the modules that assert; needs nothing else.
`ifndef RANDOM_WALK_QUOTE_GENERATOR_DEFINES_SVH
`define RANDOM_WALK_QUOTE_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define RWQG_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) \
        (ante) |-> (cons)) else $error(msg);
`define RWQG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) \
        (ante) |=> (cons)) else $error(msg);
`else
`define RWQG_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define RWQG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== src/rwqg_pkg.sv =====
// Types, constants and the xorshift step of the quote generator.
// No dependencies.
`timescale 1ns / 1ps
package rwqg_pkg;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00_0000_0000_0001,
        S_READ     = 14'b00_0000_0000_0010,
        S_LOAD_MID = 14'b00_0000_0000_0100,
        S_DIV      = 14'b00_0000_0000_1000,
        S_POST     = 14'b00_0000_0001_0000,
        S_CLAMP    = 14'b00_0000_0010_0000,
        S_WRITE    = 14'b00_0000_0100_0000,
        S_CHG_SH   = 14'b00_0000_1000_0000,
        S_CHG_ADD  = 14'b00_0001_0000_0000,
        S_CHG_SUB  = 14'b00_0010_0000_0000,
        S_CHG_FIN  = 14'b00_0100_0000_0000,
        S_EMIT     = 14'b00_1000_0000_0000,
        S_CMUL     = 14'b01_0000_0000_0000,
        S_CFIX     = 14'b10_0000_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        OP_RANGE  = 2'd0,
        OP_STEP   = 2'd1,
        OP_SPREAD = 2'd2,
        OP_VOL    = 2'd3
    } t_op;

    localparam logic CFG_ACTIVE = 1'b0;
    localparam logic CFG_SEED   = 1'b1;

    localparam logic [63:0] SEED_DEFAULT   = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [6:0]  ACTIVE_DEFAULT = 7'd7;

    localparam logic [63:0] DIV_RANGE    = 64'd2000;
    localparam logic [63:0] RANGE_FLOOR  = 64'd5000;
    localparam logic [63:0] MID_FLOOR    = 64'd1000000;
    localparam logic [63:0] DIV_SPREAD   = 64'd2500;
    localparam logic [63:0] SPREAD_FLOOR = 64'd10000;
    localparam logic [63:0] VOL_MOD      = 64'd250000;
    localparam logic [18:0] VOL_BASE     = 19'd50000;
    localparam logic [15:0] CHG_LIMIT    = 16'd10000;
    localparam logic [14:0] CHG_SCALE    = 15'd20000;
    localparam int          CHG_BITS     = 15;

    // floor(2^64 / d) for the constant divisors
    localparam logic [64:0] TWO_POW_64  = 65'd1 << 64;
    localparam logic [63:0] RCP_RANGE   = 64'(TWO_POW_64 / 65'(DIV_RANGE));
    localparam logic [63:0] RCP_SPREAD  = 64'(TWO_POW_64 / 65'(DIV_SPREAD));
    localparam logic [63:0] RCP_VOL     = 64'(TWO_POW_64 / 65'(VOL_MOD));

    // leading numerator bits that go straight into the remainder
    localparam int STEP_SKIP   = 13;

    function automatic logic [63:0] xs_next(input logic [63:0] x);
        logic [63:0] a;
        logic [63:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 7);
        xs_next = b ^ (b << 17);
    endfunction

endpackage

// ===== src/rwqg_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module rwqg_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/random_walk_quote_generator.sv =====
// Top level of the random-walk quote generator: control, shared divider, output register.
// Depends on rwqg_pkg, rwqg_ram and random_walk_quote_generator_defines.svh.
//
// Input channel (i_valid/o_ready): a load word (req_type 0) writes the starting mid of one
// slot and gives no quote. A tick word (req_type 1) walks slots 0..n-1,
// n = min(active_instruments, MAX_SLOTS, 64), and gives one quote per slot, last on the
// final one; a tick with n = 0 gives nothing.
// Output channel (o_valid/i_ready): one quote per word, held in an output register.
// The mid prices live in one RAM with a registered read. Every slot is read, walked
// and written back before the next slot is read, so no two accesses overlap.
// Division by 2000 and 2500 and the volume modulo use a reciprocal product over one
// 32x32 multiplier; the step modulo is a restoring division and the change ratio is
// skipped when the previous mid is zero or the change saturates. A new word is taken
// only between ticks; a load may be taken while the last quote still waits in the
// output register. A stalled receiver holds the walk at the point where the next
// quote would be written.
// Reset sets active_instruments to 7 and the generator to its default seed; the
// RAM is not cleared and a slot must be loaded before a tick reads it.
`timescale 1ns / 1ps
`include "random_walk_quote_generator_defines.svh"
module random_walk_quote_generator #(
    parameter int MAX_SLOTS  = 64,
    parameter int PRICE_BITS = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_req_type,
    input  logic [5:0]         i_slot,
    input  logic [47:0]        i_start_mid,
    input  logic [43:0]        i_stamp_ms,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [5:0]         o_out_slot,
    output logic [47:0]        o_bid_micros,
    output logic [47:0]        o_ask_micros,
    output logic [47:0]        o_spread_micros,
    output logic [43:0]        o_out_stamp_ms,
    output logic [18:0]        o_volume,
    output logic signed [14:0] o_change_hundredths,
    output logic               o_last
);
    import rwqg_pkg::*;

    localparam int PB   = PRICE_BITS;
    localparam int AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CAP  = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;
    localparam int STP_ITER = 64 - STEP_SKIP;
    localparam logic [PB-1:0]   PMAX     = {PB{1'b1}};
    localparam logic [63:0]     PMAX64   = 64'({PB{1'b1}});
    localparam logic signed [PB+1:0] FLOOR_S = (PB+2)'(MID_FLOOR);
    localparam logic signed [PB+1:0] PMAX_S  = {2'b00, {PB{1'b1}}};

    t_state r_state;
    t_op    r_op;
    logic [5:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_num;
    logic [63:0] r_den;
    logic [63:0] r_q;
    logic [63:0] r_rcp;
    logic [127:0] r_acc;
    logic [63:0] r_rng;
    logic [6:0]  r_active;
    logic [6:0]  r_count;
    logic [5:0]  r_idx;
    logic [43:0] r_stamp;
    logic [PB-1:0] r_mid;
    logic [PB-1:0] r_new;
    logic [PB-1:0] r_range;
    logic [PB-1:0] r_mag;
    logic [PB-1:0] r_spread;
    logic [PB-1:0] r_bid;
    logic [PB-1:0] r_ask;
    logic signed [PB+1:0] r_sum;
    logic        r_neg;
    logic [18:0] r_vol;
    logic [14:0] r_chg;

    logic        r_o_valid;
    logic [5:0]  r_o_slot;
    logic [47:0] r_o_bid;
    logic [47:0] r_o_ask;
    logic [47:0] r_o_spread;
    logic [43:0] r_o_stamp;
    logic [18:0] r_o_vol;
    logic [14:0] r_o_chg;
    logic        r_o_last;

    logic          w_accept;
    logic          w_load_we;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    logic [PB-1:0] w_ram_wdata;
    logic [PB-1:0] w_rdata;
    logic [PB-1:0] w_start_sat;
    logic [6:0]    w_count_cap;
    logic [63:0]   w_draw;
    logic [64:0]   w_trial;
    logic [64:0]   w_trial_sub;
    logic          w_div_ge;
    logic [63:0]   w_rem_step;
    logic          w_sub_ge;
    logic [31:0]   w_mul_a;
    logic [31:0]   w_mul_b;
    logic [63:0]   w_prod;
    logic [63:0]   w_qe;
    logic [63:0]   w_cres;
    logic          w_cfix_ge;
    logic [PB-1:0] w_range;
    logic [PB-1:0] w_spread;
    logic [PB-1:0] w_half;
    logic [PB:0]   w_ask_wide;
    logic [PB-1:0] w_new;
    logic [15:0]   w_round;
    logic [15:0]   w_res;
    logic          w_last;
    logic          w_out_free;
    logic          w_emit;
    logic          w_in_div;
    logic          w_vol_ok;
    logic          w_chg_ok;
    logic          w_load_acc;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_load_we = w_accept && !i_req_type && (32'(i_slot) < MAX_SLOTS);

    assign w_start_sat = (64'(i_start_mid) > PMAX64) ? PMAX : PB'(64'(i_start_mid));
    assign w_count_cap = (r_active > 7'(CAP)) ? 7'(CAP) : r_active;

    assign w_ram_we    = w_load_we || (r_state == S_WRITE);
    assign w_ram_waddr = (r_state == S_WRITE) ? AW'(r_idx) : AW'(i_slot);
    assign w_ram_wdata = (r_state == S_WRITE) ? r_new : w_start_sat;

    rwqg_ram #(
        .WIDTH (PB),
        .DEPTH (MAX_SLOTS)
    ) u_mid_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (r_state == S_READ),
        .i_raddr (AW'(r_idx)),
        .o_rdata (w_rdata)
    );

    assign w_draw      = xs_next(r_rng);
    assign w_trial     = {r_rem, r_num[63]};
    assign w_trial_sub = w_trial - {1'b0, r_den};
    assign w_div_ge    = (w_trial >= {1'b0, r_den});
    assign w_rem_step  = w_div_ge ? w_trial_sub[63:0] : w_trial[63:0];
    assign w_sub_ge    = (r_rem >= r_den);

    assign w_qe = r_acc[127:64];

    always_comb begin
        case (r_cnt[2:0])
            3'd5: begin
                w_mul_a = r_num[31:0];
                w_mul_b = r_rcp[31:0];
            end
            3'd4: begin
                w_mul_a = r_num[31:0];
                w_mul_b = r_rcp[63:32];
            end
            3'd3: begin
                w_mul_a = r_num[63:32];
                w_mul_b = r_rcp[31:0];
            end
            3'd2: begin
                w_mul_a = r_num[63:32];
                w_mul_b = r_rcp[63:32];
            end
            3'd1: begin
                w_mul_a = w_qe[31:0];
                w_mul_b = r_den[31:0];
            end
            default: begin
                w_mul_a = w_qe[63:32];
                w_mul_b = r_den[31:0];
            end
        endcase
    end

    assign w_prod    = 64'(w_mul_a) * 64'(w_mul_b);
    assign w_cres    = r_num - r_acc[63:0];
    assign w_cfix_ge = (w_cres >= r_den);

    assign w_range    = (r_q < RANGE_FLOOR) ? PB'(RANGE_FLOOR) : r_q[PB-1:0];
    assign w_spread   = (r_q < SPREAD_FLOOR) ? PB'(SPREAD_FLOOR) : r_q[PB-1:0];
    assign w_half     = w_spread >> 1;
    assign w_ask_wide = {1'b0, r_new} + {1'b0, w_half};

    assign w_new = (r_sum < FLOOR_S) ? PB'(MID_FLOOR) :
                   (r_sum > PMAX_S)  ? PMAX : r_sum[PB-1:0];

    assign w_round = (16'(r_q[CHG_BITS-1:0]) + 16'd1) >> 1;
    assign w_res   = (w_round > CHG_LIMIT) ? CHG_LIMIT : w_round;

    assign w_last     = (({1'b0, r_idx} + 7'd1) == r_count);
    assign w_out_free = !r_o_valid || i_ready;
    assign w_emit     = (r_state == S_EMIT) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_active  <= ACTIVE_DEFAULT;
            r_rng     <= SEED_DEFAULT;
        end else begin
            if (w_emit) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_ACTIVE: r_active <= i_cfg_data[6:0];
                    CFG_SEED:   r_rng <= (i_cfg_data == 64'd0) ? SEED_DEFAULT : i_cfg_data;
                    default:    r_active <= r_active;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && i_req_type) begin
                        r_stamp <= i_stamp_ms;
                        r_count <= w_count_cap;
                        r_idx   <= 6'd0;
                        if (w_count_cap != 7'd0) begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_LOAD_MID;
                end
                S_LOAD_MID: begin
                    r_mid   <= w_rdata;
                    r_num   <= 64'(w_rdata);
                    r_den   <= DIV_RANGE;
                    r_rcp   <= RCP_RANGE;
                    r_cnt   <= 6'd5;
                    r_op    <= OP_RANGE;
                    r_state <= S_CMUL;
                end
                S_CMUL: begin
                    case (r_cnt[2:0])
                        3'd5:       r_acc <= {64'd0, w_prod};
                        3'd4, 3'd3: r_acc <= r_acc + {32'd0, w_prod, 32'd0};
                        3'd2:       r_acc <= r_acc + {w_prod, 64'd0};
                        3'd1:       r_acc[63:0] <= w_prod;
                        default:    r_acc[63:0] <= r_acc[63:0] + {w_prod[31:0], 32'd0};
                    endcase
                    if (r_cnt == 6'd0) begin
                        r_state <= S_CFIX;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_CFIX: begin
                    r_rem   <= w_cfix_ge ? (w_cres - r_den) : w_cres;
                    r_q     <= w_qe + 64'(w_cfix_ge);
                    r_state <= S_POST;
                end
                S_DIV: begin
                    r_rem <= w_rem_step;
                    r_num <= r_num << 1;
                    r_q   <= {r_q[62:0], w_div_ge};
                    if (r_cnt == 6'd0) begin
                        r_state <= S_POST;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_POST: begin
                    case (r_op)
                        OP_RANGE: begin
                            r_range <= w_range;
                            r_rng   <= w_draw;
                            r_rem   <= w_draw >> STP_ITER;
                            r_num   <= w_draw << STEP_SKIP;
                            r_den   <= 64'({w_range, 1'b1});
                            r_q     <= 64'd0;
                            r_cnt   <= 6'(STP_ITER - 1);
                            r_op    <= OP_STEP;
                            r_state <= S_DIV;
                        end
                        OP_STEP: begin
                            r_sum   <= $signed({2'b00, r_mid}) + $signed({2'b00, r_rem[PB-1:0]})
                                       - $signed({2'b00, r_range});
                            r_state <= S_CLAMP;
                        end
                        OP_SPREAD: begin
                            r_spread <= w_spread;
                            r_bid    <= r_new - w_half;
                            r_ask    <= w_ask_wide[PB] ? PMAX : w_ask_wide[PB-1:0];
                            r_rng    <= w_draw;
                            r_num    <= w_draw;
                            r_den    <= VOL_MOD;
                            r_rcp    <= RCP_VOL;
                            r_cnt    <= 6'd5;
                            r_op     <= OP_VOL;
                            r_state  <= S_CMUL;
                        end
                        default: begin
                            r_vol <= VOL_BASE + 19'(r_rem[17:0]);
                            if (r_mid == '0) begin
                                r_chg   <= 15'd0;
                                r_state <= S_EMIT;
                            end else if (r_mag >= r_mid) begin
                                r_chg   <= r_neg ? 15'(~CHG_LIMIT + 16'd1) : 15'(CHG_LIMIT);
                                r_state <= S_EMIT;
                            end else begin
                                r_rem   <= 64'd0;
                                r_num   <= 64'd0;
                                r_q     <= 64'd0;
                                r_den   <= 64'(r_mid);
                                r_cnt   <= 6'(CHG_BITS - 1);
                                r_state <= S_CHG_SH;
                            end
                        end
                    endcase
                end
                S_CLAMP: begin
                    r_new   <= w_new;
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_neg   <= (r_new < r_mid);
                    r_mag   <= (r_new < r_mid) ? (r_mid - r_new) : (r_new - r_mid);
                    r_num   <= 64'(r_new);
                    r_den   <= DIV_SPREAD;
                    r_rcp   <= RCP_SPREAD;
                    r_cnt   <= 6'd5;
                    r_op    <= OP_SPREAD;
                    r_state <= S_CMUL;
                end
                S_CHG_SH: begin
                    r_rem <= w_rem_step;
                    r_q   <= {r_q[62:0], w_div_ge};
                    if (CHG_SCALE[r_cnt[3:0]]) begin
                        r_state <= S_CHG_ADD;
                    end else if (r_cnt == 6'd0) begin
                        r_state <= S_CHG_FIN;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_CHG_ADD: begin
                    r_rem   <= r_rem + 64'(r_mag);
                    r_state <= S_CHG_SUB;
                end
                S_CHG_SUB: begin
                    r_rem <= w_sub_ge ? (r_rem - r_den) : r_rem;
                    r_q   <= r_q + 64'(w_sub_ge);
                    if (r_cnt == 6'd0) begin
                        r_state <= S_CHG_FIN;
                    end else begin
                        r_cnt   <= r_cnt - 6'd1;
                        r_state <= S_CHG_SH;
                    end
                end
                S_CHG_FIN: begin
                    r_chg   <= r_neg ? 15'(~w_res + 16'd1) : 15'(w_res);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_o_slot   <= r_idx;
                        r_o_bid    <= 48'(64'(r_bid));
                        r_o_ask    <= 48'(64'(r_ask));
                        r_o_spread <= 48'(64'(r_spread));
                        r_o_stamp  <= r_stamp;
                        r_o_vol    <= r_vol;
                        r_o_chg    <= r_chg;
                        r_o_last   <= w_last;
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 6'd1;
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid             = r_o_valid;
    assign o_out_slot          = r_o_slot;
    assign o_bid_micros        = r_o_bid;
    assign o_ask_micros        = r_o_ask;
    assign o_spread_micros     = r_o_spread;
    assign o_out_stamp_ms      = r_o_stamp;
    assign o_volume            = r_o_vol;
    assign o_change_hundredths = $signed(r_o_chg);
    assign o_last              = r_o_last;

    assign w_in_div   = (r_state == S_DIV) || (r_state == S_CHG_SH);
    assign w_vol_ok   = (o_volume >= VOL_BASE) && (o_volume <= 19'd299999);
    assign w_chg_ok   = (o_change_hundredths <= 15'sd10000)
                        && (o_change_hundredths >= -15'sd10000);
    assign w_load_acc = w_accept && !i_req_type;

    `RWQG_ASSERT_IMPL(a_rem_below_den, i_clk, i_rst_n, w_in_div, r_rem < r_den, "remainder big")
    `RWQG_ASSERT_IMPL(a_vol_range, i_clk, i_rst_n, o_valid, w_vol_ok, "volume out of range")
    `RWQG_ASSERT_IMPL(a_chg_range, i_clk, i_rst_n, o_valid, w_chg_ok, "change out of range")
    `RWQG_ASSERT_NEXT(a_load_idle, i_clk, i_rst_n, w_load_acc, o_ready, "load left idle")
endmodule
